// File: rtl/slm_pkg.sv
// Shared types, constants and the log2 fraction table of the sound level meter.
package slm_pkg;

	// Register map of the configuration port.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_HPF_COEF   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_COEF  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_COEF  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR   = 3'd7;

	// Reset values of the registers.
	localparam logic [15:0] HPF_COEF_RST   = 16'd65208;
	localparam logic [15:0] REF_OFFSET_RST = 16'hF08B;
	localparam logic [15:0] TRIM_RST       = 16'hE100;
	localparam logic [14:0] FLOOR_RST      = 15'd7680;
	localparam logic [14:0] CEILING_RST    = 15'd30720;
	localparam logic [15:0] SLOW_COEF_RST  = 16'd6554;
	localparam logic [15:0] FAST_COEF_RST  = 16'd22938;
	localparam logic [14:0] JUMP_THR_RST   = 15'd3072;

	// Frame length default and queue depth between the two halves.
	localparam int MAX_FRAME_DEF = 512;
	localparam int QUEUE_DEPTH   = 4;

	// Log2 table: entries must be a power of two.
	localparam int LOG_TABLE_ENTRIES = 64;
	localparam int LOG_IDX_W         = $clog2(LOG_TABLE_ENTRIES);

	// 10*log10(2) in signed Q2.16.
	localparam logic signed [18:0] TEN_LOG10_2 = 19'sd197283;

	// Settings seen by the frame arithmetic.
	typedef struct packed {
		logic signed [15:0] ref_offset_db;
		logic signed [15:0] trim_db;
		logic [14:0]        floor_db;
		logic [14:0]        ceiling_db;
		logic [15:0]        slow_coef;
		logic [15:0]        fast_coef;
		logic [14:0]        jump_threshold_db;
	} slm_cfg_t;

	// Sequencer states of the frame arithmetic.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_INTERP,
		ST_LOG,
		ST_SCALE,
		ST_LEVEL,
		ST_SMOOTH1,
		ST_SMOOTH2,
		ST_EMIT
	} slm_state_t;

	typedef logic [16:0] log_tab_t [0:LOG_TABLE_ENTRIES];

	// log2 of a Q1.30 mantissa in [1,2) as Q0.16, by repeated squaring.
	function automatic logic [16:0] frac_log2(input logic [63:0] m_in);
		logic [63:0] m;
		logic [16:0] r;
		m = m_in;
		r = '0;
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				r[k] = 1'b1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	function automatic log_tab_t build_log_table();
		log_tab_t t;
		for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
			t[i] = frac_log2((64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES));
		end
		t[LOG_TABLE_ENTRIES] = 17'd65536;
		return t;
	endfunction

	localparam log_tab_t LOG_TABLE = build_log_table();

endpackage

// File: rtl/sound_level_meter_slow_unit.sv
// Top level of the sound level meter: configuration registers and the two halves.
//
// Input channel (in_valid/in_ready): one left-channel I2S word per item, with the
// 24-bit sample in raw_word[31:8] and frame_end marking the last item of a frame.
// A frame also ends after MAX_FRAME items without frame_end.
// Output channel (out_valid/out_ready): one smoothed level in Q7.8 dB per frame.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while the block is idle.
// The sample path takes one item per cycle. Its ready drops only while the
// four-entry frame queue could not hold every frame end still in flight.
// After its last item is accepted, a frame result goes through two sample stages,
// the queue write, two 6-step normalisations of the shared log unit, scaling and
// smoothing; a first or silent frame is quicker. The level path works on one
// frame at a time and pops the next from the queue only when idle.
// A stalled receiver holds the result register; the level path then waits
// with its next frame finished, and the queue fills before input stalls.
// Reset sets the registers to their defaults, clears the filter, the frame sum
// and count, the queue and the smoothed level; the next frame is passed unsmoothed.
module sound_level_meter_slow_unit #(
	parameter int MAX_FRAME = slm_pkg::MAX_FRAME_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [31:0]                   raw_word,
	input  logic                          frame_end,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic [14:0]                   level_db,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [slm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import slm_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	logic [15:0]      hpf_coef_q;
	slm_cfg_t         cfg_q;
	logic             push, pop, q_empty;
	logic [63:0]      push_sum, q_sum;
	logic [CNT_W-1:0] push_cnt, q_cnt;
	logic [OCC_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpf_coef_q              <= HPF_COEF_RST;
			cfg_q.ref_offset_db     <= REF_OFFSET_RST;
			cfg_q.trim_db           <= TRIM_RST;
			cfg_q.floor_db          <= FLOOR_RST;
			cfg_q.ceiling_db        <= CEILING_RST;
			cfg_q.slow_coef         <= SLOW_COEF_RST;
			cfg_q.fast_coef         <= FAST_COEF_RST;
			cfg_q.jump_threshold_db <= JUMP_THR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HPF_COEF:   hpf_coef_q              <= cfg_data;
				REG_REF_OFFSET: cfg_q.ref_offset_db     <= cfg_data;
				REG_TRIM:       cfg_q.trim_db           <= cfg_data;
				REG_FLOOR:      cfg_q.floor_db          <= cfg_data[14:0];
				REG_CEILING:    cfg_q.ceiling_db        <= cfg_data[14:0];
				REG_SLOW_COEF:  cfg_q.slow_coef         <= cfg_data;
				REG_FAST_COEF:  cfg_q.fast_coef         <= cfg_data;
				REG_JUMP_THR:   cfg_q.jump_threshold_db <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	slm_front #(.MAX_FRAME(MAX_FRAME), .CNT_W(CNT_W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw_word (raw_word),
		.frame_end(frame_end),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.hpf_coef (hpf_coef_q),
		.q_count  (q_count),
		.push     (push),
		.push_sum (push_sum),
		.push_cnt (push_cnt)
	);

	slm_queue #(.WIDTH(64 + CNT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_sum, push_cnt}),
		.pop      (pop),
		.pop_data ({q_sum, q_cnt}),
		.empty    (q_empty),
		.count    (q_count)
	);

	slm_back #(.CNT_W(CNT_W)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_sum    (q_sum),
		.q_cnt    (q_cnt),
		.pop      (pop),
		.level_db (level_db),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

endmodule

// File: rtl/slm_front.sv
// Sample path: DC-blocking filter, squaring and the saturating frame sum.
module slm_front #(
	parameter int MAX_FRAME = slm_pkg::MAX_FRAME_DEF,
	parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        raw_word,
	input  logic               frame_end,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        hpf_coef,
	input  logic [$clog2(slm_pkg::QUEUE_DEPTH+1)-1:0] q_count,
	output logic               push,
	output logic [63:0]        push_sum,
	output logic [CNT_W-1:0]   push_cnt
);
	import slm_pkg::*;

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	logic signed [23:0] prev_sample_q;
	logic signed [39:0] prev_filt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [63:0]        sum_q;

	logic               v_s1, end_s1;
	logic signed [39:0] y_s1;
	logic [CNT_W-1:0]   cnt_s1;
	logic               v_s2, end_s2;
	logic [63:0]        sq_s2;
	logic [CNT_W-1:0]   cnt_s2;

	logic               accept;
	logic signed [23:0] x;
	logic signed [24:0] diff;
	logic signed [40:0] t;
	logic signed [57:0] prod;
	logic signed [41:0] y_wide;
	logic signed [39:0] y;
	logic [CNT_W-1:0]   cnt_inc;
	logic               is_end;
	logic signed [40:0] y_rnd;
	logic signed [32:0] yi;
	logic [31:0]        ayi;
	logic [64:0]        sum_add;
	logic [63:0]        sum_next;
	logic [OCC_W+1:0]   pending;

	// Take an item only while the queue is sure to have room for every frame in flight.
	assign pending  = (OCC_W+2)'(q_count) + (OCC_W+2)'(end_s1 & v_s1)
		+ (OCC_W+2)'(end_s2 & v_s2);
	assign in_ready = pending < (OCC_W+2)'(QUEUE_DEPTH);
	assign accept   = in_valid & in_ready;

	// Filter step: y = coef * (y_prev + (x - x_prev) * 256) / 65536, rounded and saturated.
	always_comb begin
		x      = $signed(raw_word[31:8]);
		diff   = 25'(x) - 25'(prev_sample_q);
		t      = 41'(prev_filt_q) + (41'(diff) <<< 8);
		prod   = 58'(t) * $signed({42'd0, hpf_coef});
		y_wide = 42'((prod + 58'sd32768) >>> 16);
		if (y_wide > 42'sh7F_FFFF_FFFF) begin
			y = 40'sh7F_FFFF_FFFF;
		end else if (y_wide < -42'sh80_0000_0000) begin
			y = -40'sh80_0000_0000;
		end else begin
			y = 40'(y_wide);
		end
		cnt_inc = cnt_q + CNT_W'(1);
		is_end  = frame_end | (cnt_inc >= CNT_W'(MAX_FRAME));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q <= '0;
			prev_filt_q   <= '0;
			cnt_q         <= '0;
			v_s1          <= 1'b0;
			end_s1        <= 1'b0;
		end else begin
			v_s1   <= accept;
			end_s1 <= accept & is_end;
			if (accept) begin
				prev_sample_q <= x;
				prev_filt_q   <= y;
				cnt_q         <= is_end ? '0 : cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y_s1   <= y;
			cnt_s1 <= cnt_inc;
		end
	end

	// Round the filter output to an integer and square its magnitude.
	always_comb begin
		y_rnd = 41'(y_s1) + 41'sd128;
		yi    = 33'(y_rnd >>> 8);
		ayi   = yi[32] ? 32'(-yi) : 32'(yi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			end_s2 <= 1'b0;
		end else begin
			v_s2   <= v_s1;
			end_s2 <= v_s1 & end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sq_s2  <= 64'(ayi) * 64'(ayi);
			cnt_s2 <= cnt_s1;
		end
	end

	// Saturating frame sum; a frame end hands the total to the queue.
	always_comb begin
		sum_add  = 65'(sum_q) + 65'(sq_s2);
		sum_next = sum_add[64] ? '1 : sum_add[63:0];
	end

	assign push     = v_s2 & end_s2;
	assign push_sum = sum_next;
	assign push_cnt = cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v_s2) begin
			sum_q <= end_s2 ? '0 : sum_next;
		end
	end

endmodule

// File: rtl/slm_queue.sv
// Short register queue carrying frame totals from the sample path to the level path.
module slm_queue #(
	parameter int WIDTH = 74,
	parameter int DEPTH = slm_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import slm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]           mem_q [DEPTH];
	logic [PTR_W-1:0]           wr_q, rd_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	assign count    = count_q;
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_q];

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			count_q <= count_q + ($clog2(DEPTH+1))'(push) - ($clog2(DEPTH+1))'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < ($clog2(DEPTH+1))'(DEPTH) || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ($clog2(DEPTH+1))'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/slm_back.sv
// Frame level path: log2 of sum and count, dB scaling, clamp and smoothing.
module slm_back #(
	parameter int CNT_W = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slm_pkg::slm_cfg_t  cfg,
	input  logic               q_empty,
	input  logic [63:0]        q_sum,
	input  logic [CNT_W-1:0]   q_cnt,
	output logic               pop,
	output logic [14:0]        level_db,
	output logic               out_valid,
	input  logic               out_ready
);
	import slm_pkg::*;

	slm_state_t state_q, state_d;

	logic [63:0]        x_q;
	logic [5:0]         e_q;
	logic [2:0]         step_q;
	logic               op_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               zero_q;
	logic               first_q;
	logic [16:0]        lo_q;
	logic [48:0]        ip_q;
	logic [21:0]        lsum_q;
	logic signed [22:0] d_q;
	logic signed [41:0] scale_q;
	logic [14:0]        lvl_q;
	logic [15:0]        coef_q;
	logic [30:0]        p1_q;
	logic [32:0]        p2_q;
	logic [15:0]        smooth_q;
	logic [15:0]        res_q;
	logic               out_valid_q;
	logic [14:0]        out_q;

	logic [6:0]           sh;
	logic                 top_zero;
	logic [LOG_IDX_W-1:0] idx;
	logic [31:0]          frac;
	logic [31:0]          rem;
	logic [16:0]          lo, hi;
	logic [21:0]          log_val;
	logic signed [17:0]   db_r;
	logic signed [18:0]   db;
	logic [14:0]          lvl;
	logic signed [16:0]   rise;
	logic [33:0]          sm_sum;
	logic                 emit;

	// Binary normalising step: shift out 32, 16, ... 1 leading zeros.
	always_comb begin
		sh       = 7'(7'd32 >> step_q);
		top_zero = (x_q >> (7'd64 - sh)) == 64'd0;
	end

	// Table lookup with linear interpolation on the mantissa.
	always_comb begin
		frac    = x_q[62:31];
		idx     = frac[31 -: LOG_IDX_W];
		rem     = frac << LOG_IDX_W;
		lo      = LOG_TABLE[idx];
		hi      = LOG_TABLE[(LOG_IDX_W+1)'(idx) + (LOG_IDX_W+1)'(1)];
		log_val = {e_q, 16'd0} + 22'(lo_q) + 22'(ip_q[48:32]);
	end

	// Round to signed Q9.8, add offsets (only the trim for a silent frame) and clamp, floor first.
	always_comb begin
		db_r = 18'((scale_q + 42'sd8388608) >>> 24);
		if (zero_q) begin
			db = 19'(cfg.trim_db);
		end else begin
			db = 19'(db_r) + 19'(cfg.ref_offset_db) + 19'(cfg.trim_db);
		end
		if (db < $signed({4'd0, cfg.floor_db})) begin
			db = $signed({4'd0, cfg.floor_db});
		end
		if (db > $signed({4'd0, cfg.ceiling_db})) begin
			db = $signed({4'd0, cfg.ceiling_db});
		end
		lvl    = db[14:0];
		rise   = $signed({2'd0, lvl}) - $signed({1'b0, smooth_q});
		sm_sum = 34'(p1_q) + 34'(p2_q) + 34'd32768;
	end

	// Sequencer: next state and handshakes.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = (q_sum == 64'd0) ? ST_LEVEL : ST_NORM;
				end
			end
			ST_NORM: begin
				if (step_q == 3'd5) begin
					state_d = ST_INTERP;
				end
			end
			ST_INTERP: state_d = ST_LOG;
			ST_LOG:    state_d = op_q ? ST_SCALE : ST_NORM;
			ST_SCALE:  state_d = ST_LEVEL;
			ST_LEVEL:  state_d = first_q ? ST_EMIT : ST_SMOOTH1;
			ST_SMOOTH1: state_d = ST_SMOOTH2;
			ST_SMOOTH2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b1;
			smooth_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				first_q     <= 1'b0;
				smooth_q    <= first_q ? res_q : sm_sum[31:16];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the frame arithmetic.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= q_sum;
				cnt_q  <= q_cnt;
				zero_q <= q_sum == 64'd0;
				e_q    <= 6'd63;
				step_q <= '0;
				op_q   <= 1'b0;
			end
			ST_NORM: begin
				if (top_zero) begin
					x_q <= x_q << sh;
					e_q <= e_q - 6'(sh);
				end
				step_q <= step_q + 3'd1;
			end
			ST_INTERP: begin
				lo_q <= lo;
				ip_q <= 49'(hi - lo) * 49'(rem);
			end
			ST_LOG: begin
				lsum_q <= log_val;
				d_q    <= $signed({1'b0, lsum_q}) - $signed({1'b0, log_val});
				x_q    <= 64'(cnt_q);
				e_q    <= 6'd63;
				step_q <= '0;
				op_q   <= 1'b1;
			end
			ST_SCALE: begin
				scale_q <= 42'(d_q) * 42'(TEN_LOG10_2);
			end
			ST_LEVEL: begin
				lvl_q  <= lvl;
				res_q  <= {1'b0, lvl};
				coef_q <= (rise > $signed({2'd0, cfg.jump_threshold_db})) ?
					cfg.fast_coef : cfg.slow_coef;
			end
			ST_SMOOTH1: begin
				p1_q <= 31'(coef_q) * 31'(lvl_q);
			end
			ST_SMOOTH2: begin
				p2_q <= (33'd65536 - 33'(coef_q)) * 33'(smooth_q);
			end
			ST_EMIT: begin
				if (!first_q) begin
					res_q <= sm_sum[31:16];
				end
				if (emit) begin
					out_q <= first_q ? res_q[14:0] : sm_sum[30:16];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign level_db  = out_q;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE)
		else $error("frame taken while busy");
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result not presented");
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NORM |-> step_q <= 3'd5)
		else $error("normalise ran too long");
`endif

endmodule
